[rtl/core/haversine_proximity_filter_top_defines.svh]
// Assertion macros shared by the proximity filter RTL.
`ifndef HAVERSINE_PROXIMITY_FILTER_TOP_DEFINES_SVH
`define HAVERSINE_PROXIMITY_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/hpf_pkg.sv]
package hpf_pkg;

    // Field widths of the ports.
    localparam int LAT_W      = 30;
    localparam int LON_W      = 31;
    localparam int DIST_W     = 25;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    // Defaults of the top-level parameters.
    localparam int ANGLE_FRAC_BITS_DEF = 22;
    localparam int DIST_FRAC_BITS_DEF  = 10;
    localparam int CORDIC_STAGES_DEF   = 24;

    // Degree to binary-angle conversion: long division by 360, a few bits per cell.
    localparam int DIV_W     = 48;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CELLS = DIV_W / DIV_STEPS;
    localparam int DIV_REM_W = 9;
    localparam logic [DIV_REM_W:0] DEG_FULL_TURN = 10'd360;
    localparam logic [DIV_W-1:0]   DEG_HALF_TURN = 48'd180;
    localparam int TURN_W    = 32;

    // CORDIC datapath width and constants.
    localparam int CW = 34;
    localparam logic signed [CW-1:0] KGAIN_Q30 = 34'sd652032874;
    localparam logic [31:0] CIRC_Q16     = 32'd2623417457;
    localparam longint unsigned HALF_CIRC_KM = 64'd20015;

    // Square root: one result bit per cell.
    localparam int ROOT_W     = 31;
    localparam int SQRT_IN_W  = 2 * ROOT_W;
    localparam int SQRT_REM_W = ROOT_W + 2;
    localparam int A_W        = 61;
    localparam logic [A_W-1:0] ONE_Q60 = {1'b1, {(A_W-1){1'b0}}};

    // Arctangent of 2^-k in binary angle units (2^32 per turn).
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_REF_LAT  = 2'd0,
        REG_REF_LON  = 2'd1,
        REG_MAX_DIST = 2'd2
    } hpf_reg_t;

    // Lane state of one division cell.
    typedef struct packed {
        logic [DIV_W-1:0]     num;
        logic [DIV_REM_W-1:0] rem;
        logic [TURN_W-1:0]    quo;
        logic                 neg;
    } div_lane_t;

    // Lane state of one rotation cell.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [TURN_W-1:0]    z;
        logic                 flip;
    } rot_lane_t;

    // Lane state of one vectoring cell.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vec_lane_t;

    // Lane state of one square-root cell.
    typedef struct packed {
        logic [SQRT_IN_W-1:0]  num;
        logic [SQRT_REM_W-1:0] rem;
        logic [ROOT_W-1:0]     root;
    } sqrt_lane_t;

endpackage

[rtl/core/hpf_div_cell.sv]
module hpf_div_cell (
    input  logic               clk,
    input  logic               en,
    input  hpf_pkg::div_lane_t lane_in,
    output hpf_pkg::div_lane_t lane_out
);
    import hpf_pkg::*;

    div_lane_t lane_reg;
    div_lane_t lane_next;

    // Restoring division by 360, a few quotient bits per cell.
    always_comb
    begin
        logic [DIV_REM_W:0] trial;
        lane_next = lane_in;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {lane_next.rem, lane_next.num[DIV_W-1]};
            lane_next.num = {lane_next.num[DIV_W-2:0], 1'b0};
            if (trial >= DEG_FULL_TURN)
            begin
                lane_next.rem = DIV_REM_W'(trial - DEG_FULL_TURN);
                lane_next.quo = {lane_next.quo[TURN_W-2:0], 1'b1};
            end
            else
            begin
                lane_next.rem = trial[DIV_REM_W-1:0];
                lane_next.quo = {lane_next.quo[TURN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

[rtl/core/hpf_rot_cell.sv]
module hpf_rot_cell #(
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               en,
    input  hpf_pkg::rot_lane_t lane_in,
    output hpf_pkg::rot_lane_t lane_out
);
    import hpf_pkg::*;

    rot_lane_t lane_reg;
    rot_lane_t lane_next;

    // One rotation step: turn toward zero residual angle.
    always_comb
    begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = lane_in.x >>> SHIFT;
        ys = lane_in.y >>> SHIFT;
        lane_next.flip = lane_in.flip;
        if (lane_in.z[TURN_W-1])
        begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + ATAN_TURNS[SHIFT];
        end
        else
        begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - ATAN_TURNS[SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

[rtl/core/hpf_vec_cell.sv]
module hpf_vec_cell #(
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               en,
    input  hpf_pkg::vec_lane_t lane_in,
    output hpf_pkg::vec_lane_t lane_out
);
    import hpf_pkg::*;

    vec_lane_t lane_reg;
    vec_lane_t lane_next;

    // One vectoring step: drive y toward zero and accumulate the angle.
    always_comb
    begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] step;
        xs   = lane_in.x >>> SHIFT;
        ys   = lane_in.y >>> SHIFT;
        step = $signed({{(CW-32){1'b0}}, ATAN_TURNS[SHIFT]});
        if (lane_in.y > 0)
        begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + step;
        end
        else
        begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

[rtl/core/hpf_sqrt_cell.sv]
module hpf_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  hpf_pkg::sqrt_lane_t lane_in,
    output hpf_pkg::sqrt_lane_t lane_out
);
    import hpf_pkg::*;

    sqrt_lane_t lane_reg;
    sqrt_lane_t lane_next;

    // One digit of the integer square root: bring down two bits, try 4*root+1.
    always_comb
    begin
        logic [SQRT_REM_W+1:0] part;
        logic [SQRT_REM_W+1:0] trial;
        part  = {lane_in.rem, lane_in.num[SQRT_IN_W-1 -: 2]};
        trial = {2'b00, lane_in.root, 2'b01};
        lane_next.num = {lane_in.num[SQRT_IN_W-3:0], 2'b00};
        if (part >= trial)
        begin
            lane_next.rem  = SQRT_REM_W'(part - trial);
            lane_next.root = {lane_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = part[SQRT_REM_W-1:0];
            lane_next.root = {lane_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

[rtl/core/haversine_proximity_filter_top.sv]
// Throughput: one request per cycle while the chain is not stalled; every stage of the
// cell chains advances together, from the entry register through the output register.
// A stalled result freezes the whole chain, and the output register frees it again.
// Reset clears all valid bits and loads the reference position with zero and the
// acceptance radius with 5 km; datapath registers are not reset.
`include "haversine_proximity_filter_top_defines.svh"

module haversine_proximity_filter_top #(
    parameter int ANGLE_FRAC_BITS = hpf_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int DIST_FRAC_BITS  = hpf_pkg::DIST_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = hpf_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hpf_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [hpf_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [hpf_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 cand_valid,
    output logic                                 cand_stall,
    input  logic signed [hpf_pkg::LAT_W-1:0]     other_latitude,
    input  logic signed [hpf_pkg::LON_W-1:0]     other_longitude,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [hpf_pkg::DIST_W-1:0]           distance_km,
    output logic                                 within_range
);
    import hpf_pkg::*;

    localparam int HALF_SHIFT = 31 - ANGLE_FRAC_BITS;
    localparam int FULL_SHIFT = 32 - ANGLE_FRAC_BITS;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int PIPE_D     = 1 + DIV_CELLS + CORDIC_STAGES + 5 + SQRT_CELLS
                                + CORDIC_STAGES + 1;
    localparam int PW         = 2 * CW;
    localparam int DIST_SH    = 47 - DIST_FRAC_BITS;
    localparam longint unsigned LIM_FULL = HALF_CIRC_KM << DIST_FRAC_BITS;
    localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 64'd1;
    localparam longint unsigned LIM_64   = (LIM_FULL > DIST_MAX) ? DIST_MAX : LIM_FULL;
    localparam logic [DIST_W-1:0] DIST_LIM = DIST_W'(LIM_64);

    // Magnitude, scale and rounding offset ahead of the division by 360.
    function automatic div_lane_t div_prep(input logic signed [32:0] deg, input int sh);
        logic [32:0] mag;
        div_lane_t   r;
        mag   = deg[32] ? 33'(-deg) : 33'(deg);
        r.num = (DIV_W'(mag) << sh) + DEG_HALF_TURN;
        r.rem = '0;
        r.quo = '0;
        r.neg = deg[32];
        return r;
    endfunction

    // Signed binary angle, with a half-turn pre-rotation for the left half-plane.
    function automatic rot_lane_t rot_prep(input div_lane_t d);
        logic [TURN_W-1:0] turns;
        logic [TURN_W-1:0] probe;
        rot_lane_t         r;
        turns  = d.neg ? (TURN_W'(0) - d.quo) : d.quo;
        probe  = turns + 32'h4000_0000;
        r.flip = probe[TURN_W-1];
        r.z    = r.flip ? (turns ^ 32'h8000_0000) : turns;
        r.x    = KGAIN_Q30;
        r.y    = '0;
        return r;
    endfunction

    logic signed [LAT_W-1:0] ref_lat_reg;
    logic signed [LON_W-1:0] ref_lon_reg;
    logic [DIST_W-1:0]       max_dist_reg;
    hpf_reg_t                wr_idx;
    logic                    cfg_wr;

    logic                    en;
    logic                    accept;
    logic [PIPE_D-1:0]       vld_reg;

    logic signed [32:0]      s0_d_reg  [4];
    logic signed [32:0]      s0_d_next [4];

    div_lane_t               div_lane  [4][DIV_CELLS+1];
    rot_lane_t               rot_lane  [4][CORDIC_STAGES+1];
    sqrt_lane_t              sqrt_lane [2][SQRT_CELLS+1];
    vec_lane_t               vec_lane  [CORDIC_STAGES+1];

    logic signed [CW-1:0]    fx_s1_reg, fx_s2_reg, fx_c1_reg, fx_c2_reg;
    logic signed [PW-1:0]    p1_cc_reg, p1_ss_reg;
    logic signed [CW-1:0]    p1_s2_reg;
    logic signed [PW-1:0]    p2_us_reg, p2_ss_reg;
    logic signed [CW-1:0]    p2_s2_reg;
    logic signed [CW-1:0]    p2_u;
    logic signed [PW-1:0]    p3_vs_reg, p3_ss_reg;
    logic signed [CW-1:0]    p3_v;
    logic signed [PW:0]      p4_sum;
    logic [A_W-1:0]          a_reg, a_next;
    logic [30:0]             zc;
    logic [62:0]             d1_prod_reg;
    logic [63:0]             d_sum, d_shift;
    logic [DIST_W-1:0]       dist_next;

    logic                    res_valid_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    within_reg;

    // Configuration port: writes land on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = hpf_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg  <= '0;
            ref_lon_reg  <= '0;
            max_dist_reg <= DIST_W'(5120);
        end
        else if (cfg_wr)
        begin
            unique case (wr_idx)
                REG_REF_LAT:  ref_lat_reg  <= pwdata[LAT_W-1:0];
                REG_REF_LON:  ref_lon_reg  <= pwdata[LON_W-1:0];
                REG_MAX_DIST: max_dist_reg <= pwdata[DIST_W-1:0];
                default:      ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (wr_idx)
            REG_REF_LAT:  prdata = {{(CFG_DATA_W-LAT_W){1'b0}}, ref_lat_reg};
            REG_REF_LON:  prdata = {{(CFG_DATA_W-LON_W){1'b0}}, ref_lon_reg};
            REG_MAX_DIST: prdata = {{(CFG_DATA_W-DIST_W){1'b0}}, max_dist_reg};
            default:      prdata = '0;
        endcase
    end

    // The chain moves whenever the output register is free or being emptied.
    assign en         = !res_valid_reg || !res_stall;
    assign cand_stall = !en;
    assign accept     = cand_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_D-2:0], accept};
        end
    end

    // Entry stage: coordinate differences and the latitudes themselves.
    always_comb
    begin
        s0_d_next[0] = 33'(other_latitude) - 33'(ref_lat_reg);
        s0_d_next[1] = 33'(other_longitude) - 33'(ref_lon_reg);
        s0_d_next[2] = 33'(ref_lat_reg);
        s0_d_next[3] = 33'(other_latitude);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                s0_d_reg[l] <= s0_d_next[l];
            end
        end
    end

    // Conversion to binary angles: half angles for the differences, full for latitudes.
    for (genvar l = 0; l < 4; l++)
    begin : g_div
        if (l < 2)
        begin : g_half
            assign div_lane[l][0] = div_prep(s0_d_reg[l], HALF_SHIFT);
        end
        else
        begin : g_full
            assign div_lane[l][0] = div_prep(s0_d_reg[l], FULL_SHIFT);
        end
        for (genvar c = 0; c < DIV_CELLS; c++)
        begin : g_cell
            hpf_div_cell u_cell (
                .clk      (clk),
                .en       (en),
                .lane_in  (div_lane[l][c]),
                .lane_out (div_lane[l][c+1])
            );
        end
    end

    // Sine and cosine by rotation, one lane per angle.
    for (genvar l = 0; l < 4; l++)
    begin : g_rot
        assign rot_lane[l][0] = rot_prep(div_lane[l][DIV_CELLS]);
        for (genvar c = 0; c < CORDIC_STAGES; c++)
        begin : g_cell
            hpf_rot_cell #(.SHIFT(c)) u_cell (
                .clk      (clk),
                .en       (en),
                .lane_in  (rot_lane[l][c]),
                .lane_out (rot_lane[l][c+1])
            );
        end
    end

    // Undo the half-turn pre-rotation, then build a in three multiply stages.
    assign p2_u = CW'(p1_cc_reg >>> 30);
    assign p3_v = CW'(p2_us_reg >>> 30);
    assign p4_sum = (PW+1)'(p3_ss_reg) + (PW+1)'(p3_vs_reg);

    always_comb
    begin
        if (p4_sum < 0)
        begin
            a_next = '0;
        end
        else if (p4_sum > $signed({{(PW+1-A_W){1'b0}}, ONE_Q60}))
        begin
            a_next = ONE_Q60;
        end
        else
        begin
            a_next = p4_sum[A_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_s1_reg <= rot_lane[0][CORDIC_STAGES].flip ? -rot_lane[0][CORDIC_STAGES].y
                                                         : rot_lane[0][CORDIC_STAGES].y;
            fx_s2_reg <= rot_lane[1][CORDIC_STAGES].flip ? -rot_lane[1][CORDIC_STAGES].y
                                                         : rot_lane[1][CORDIC_STAGES].y;
            fx_c1_reg <= rot_lane[2][CORDIC_STAGES].flip ? -rot_lane[2][CORDIC_STAGES].x
                                                         : rot_lane[2][CORDIC_STAGES].x;
            fx_c2_reg <= rot_lane[3][CORDIC_STAGES].flip ? -rot_lane[3][CORDIC_STAGES].x
                                                         : rot_lane[3][CORDIC_STAGES].x;
            p1_cc_reg <= fx_c1_reg * fx_c2_reg;
            p1_ss_reg <= fx_s1_reg * fx_s1_reg;
            p1_s2_reg <= fx_s2_reg;
            p2_us_reg <= p2_u * p1_s2_reg;
            p2_ss_reg <= p1_ss_reg;
            p2_s2_reg <= p1_s2_reg;
            p3_vs_reg <= p3_v * p2_s2_reg;
            p3_ss_reg <= p2_ss_reg;
            a_reg     <= a_next;
        end
    end

    // Square roots of a and of 1 - a.
    assign sqrt_lane[0][0] = '{num: SQRT_IN_W'(a_reg), rem: '0, root: '0};
    assign sqrt_lane[1][0] = '{num: SQRT_IN_W'(ONE_Q60 - a_reg), rem: '0, root: '0};

    for (genvar l = 0; l < 2; l++)
    begin : g_sqrt
        for (genvar c = 0; c < SQRT_CELLS; c++)
        begin : g_cell
            hpf_sqrt_cell u_cell (
                .clk      (clk),
                .en       (en),
                .lane_in  (sqrt_lane[l][c]),
                .lane_out (sqrt_lane[l][c+1])
            );
        end
    end

    // Central angle by vectoring.
    assign vec_lane[0].y = $signed({{(CW-ROOT_W){1'b0}}, sqrt_lane[0][SQRT_CELLS].root});
    assign vec_lane[0].x = $signed({{(CW-ROOT_W){1'b0}}, sqrt_lane[1][SQRT_CELLS].root});
    assign vec_lane[0].z = '0;

    for (genvar c = 0; c < CORDIC_STAGES; c++)
    begin : g_vec
        hpf_vec_cell #(.SHIFT(c)) u_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (vec_lane[c]),
            .lane_out (vec_lane[c+1])
        );
    end

    // Clamp the angle to a quarter turn and scale by the circumference.
    always_comb
    begin
        if (vec_lane[CORDIC_STAGES].z < 0)
        begin
            zc = '0;
        end
        else if (vec_lane[CORDIC_STAGES].z > $signed(CW'(34'h0_4000_0000)))
        begin
            zc = 31'h4000_0000;
        end
        else
        begin
            zc = vec_lane[CORDIC_STAGES].z[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_prod_reg <= 63'(zc) * 63'(CIRC_Q16);
        end
    end

    // Round, saturate and compare against the radius.
    assign d_sum   = 64'(d1_prod_reg) + (64'd1 << (DIST_SH - 1));
    assign d_shift = d_sum >> DIST_SH;
    assign dist_next = (d_shift > LIM_64) ? DIST_LIM : d_shift[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= vld_reg[PIPE_D-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[PIPE_D-1])
        begin
            dist_reg   <= dist_next;
            within_reg <= (dist_next <= max_dist_reg);
        end
    end

    assign res_valid    = res_valid_reg;
    assign distance_km  = dist_reg;
    assign within_range = within_reg;

    // An accepted request always occupies the first stage on the next cycle.
    `HPF_ASSERT_NEXT(a_accept_enters, clk, rst_n, cand_valid && !cand_stall, vld_reg[0])
    // The input is held back only while a result waits in the output register.
    `HPF_ASSERT_IMPL(a_stall_only_full, clk, rst_n, cand_stall, res_valid_reg && res_stall)
    // A delivered distance never exceeds the saturation limit.
    `HPF_ASSERT_IMPL(a_dist_capped, clk, rst_n, res_valid, distance_km <= DIST_LIM)

endmodule

[dv/hpf_checker.sv]
`default_nettype none

// Watches the configuration port and both request channels, predicts the
// distance and range flag of every accepted candidate, and compares.
module hpf_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [hpf_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire logic [hpf_pkg::CFG_DATA_W-1:0]       pwdata,
    input  wire logic                                 pready,
    input  wire logic                                 cand_valid,
    input  wire logic                                 cand_stall,
    input  wire logic signed [hpf_pkg::LAT_W-1:0]     other_latitude,
    input  wire logic signed [hpf_pkg::LON_W-1:0]     other_longitude,
    input  wire logic                                 res_valid,
    input  wire logic                                 res_stall,
    input  wire logic [hpf_pkg::DIST_W-1:0]           distance_km,
    input  wire logic                                 within_range,
    output int                                        fail_count,
    output int                                        pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hpf_pkg::*;

    localparam int STAGES   = CORDIC_STAGES_DEF;
    localparam int DIST_SH  = 47 - DIST_FRAC_BITS_DEF;
    localparam longint unsigned ONE60    = 64'd1 << 60;
    localparam longint unsigned DIST_LIM = HALF_CIRC_KM << DIST_FRAC_BITS_DEF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              near;
    } proximity_t;

    // Local copy of the configuration registers.
    logic signed [LAT_W-1:0] home_lat;
    logic signed [LON_W-1:0] home_lon;
    logic [DIST_W-1:0]       radius;

    proximity_t expected_q [$];

    assign pending = expected_q.size();

    // Degrees (scaled) to a binary angle, rounding the magnitude half away.
    function automatic logic [31:0] deg_to_turns(input longint deg, input int sh);
        longint unsigned mag;
        longint unsigned quo;
        logic [31:0]     r;
        mag = (deg < 0) ? longint'(-deg) : longint'(deg);
        quo = ((mag << sh) + 64'd180) / 64'd360;
        r = quo[31:0];
        return (deg < 0) ? (32'd0 - r) : r;
    endfunction

    // Rotation-mode CORDIC giving Q30 sine and cosine.
    function automatic void rotate(input logic [31:0] ang, output longint sn,
                                   output longint cs);
        longint      x;
        longint      y;
        longint      nx;
        logic [31:0] z;
        logic [31:0] probe;
        logic        flip;
        x = longint'(KGAIN_Q30);
        y = 0;
        z = ang;
        probe = z + 32'h4000_0000;
        flip = probe[31];
        if (flip)
            z = z - 32'h8000_0000;
        for (int i = 0; i < STAGES; i++)
        begin
            if (z[31])
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_TURNS[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_TURNS[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // Exact floored integer square root.
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring-mode CORDIC, result clamped to the first quadrant.
    function automatic longint quadrant_angle(input longint y, input longint x);
        longint z;
        longint nx;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_TURNS[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        if (z < 0)
            z = 0;
        if (z > 64'sh4000_0000)
            z = 64'sh4000_0000;
        return z;
    endfunction

    // Haversine distance from the home position and the range decision.
    function automatic proximity_t great_circle(input longint lat_o, input longint lon_o);
        longint          lat_h;
        longint          lon_h;
        longint          s1, s2, c1, c2, unused, u, v, a;
        longint unsigned sa, sb, z, d;
        proximity_t      res;
        lat_h = longint'(home_lat);
        lon_h = longint'(home_lon);
        rotate(deg_to_turns(lat_o - lat_h, 31 - ANGLE_FRAC_BITS_DEF), s1, unused);
        rotate(deg_to_turns(lon_o - lon_h, 31 - ANGLE_FRAC_BITS_DEF), s2, unused);
        rotate(deg_to_turns(lat_h, 32 - ANGLE_FRAC_BITS_DEF), unused, c1);
        rotate(deg_to_turns(lat_o, 32 - ANGLE_FRAC_BITS_DEF), unused, c2);
        u = (c1 * c2) >>> 30;
        v = (u * s2) >>> 30;
        a = s1 * s1 + v * s2;
        if (a < 0)
            a = 0;
        if (a > longint'(ONE60))
            a = longint'(ONE60);
        sa = root_floor(a);
        sb = root_floor(ONE60 - a);
        z = quadrant_angle(longint'(sa), longint'(sb));
        d = (z * longint'(CIRC_Q16) + (64'd1 << (DIST_SH - 1))) >> DIST_SH;
        if (d > DIST_LIM)
            d = DIST_LIM;
        res.distance = d[DIST_W-1:0];
        res.near = (d <= longint'(radius));
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        proximity_t want;
        if (!rst_n)
        begin
            home_lat   <= '0;
            home_lon   <= '0;
            radius     <= 25'd5120;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            // Register writes.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_REF_LAT:  home_lat <= pwdata[LAT_W-1:0];
                    REG_REF_LON:  home_lon <= pwdata[LON_W-1:0];
                    REG_MAX_DIST: radius   <= pwdata[DIST_W-1:0];
                    default: ;
                endcase
            end

            // Accepted candidates queue up their predicted results.
            if (cand_valid && !cand_stall)
                expected_q = {expected_q, great_circle(longint'(other_latitude),
                                                       longint'(other_longitude))};

            // Compare each delivered result with the oldest prediction.
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: dist %0d flag %0b",
                                 distance_km, within_range);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.distance !== distance_km || want.near !== within_range)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: dist exp %0d got %0d, flag exp %0b got %0b",
                                     want.distance, distance_km, want.near, within_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[dv/tb_haversine_proximity_filter_top.sv]
`default_nettype none

module tb_haversine_proximity_filter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hpf_pkg::*;

    localparam int LAT_MAX   = 377487360;
    localparam int LON_MAX   = 754974720;
    localparam int DIST_TOP  = 20495360;
    localparam int WATCHDOG  = 20000;
    localparam int PER_PHASE = 85;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;
    logic cand_valid = 1'b0;
    logic cand_stall;
    logic signed [LAT_W-1:0] other_latitude = '0;
    logic signed [LON_W-1:0] other_longitude = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [DIST_W-1:0] distance_km;
    logic within_range;

    int fail_count;
    int pending;
    int gap_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int home_lat = 0;
    int home_lon = 0;

    always #1 clk = ~clk;

    haversine_proximity_filter_top dut (.*);

    hpf_checker checker_i (.*);

    // Random receiver stalls.
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    // Ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((cand_valid && !cand_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG)
        begin
            $display("tb_haversine_proximity_filter_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Writes one register through a setup and an access cycle.
    task automatic write_reg(input hpf_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits for the pipeline to drain, then loads a new reference and radius.
    task automatic set_home(input int lat, input int lon, input logic [31:0] rad);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        write_reg(REG_REF_LAT, lat);
        write_reg(REG_REF_LON, lon);
        write_reg(REG_MAX_DIST, rad);
        home_lat = lat;
        home_lon = lon;
    endtask

    // Presents one candidate request and waits until it is taken.
    task automatic send(input int lat, input int lon);
        if ($urandom_range(99) < gap_pct)
        begin
            cand_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
        cand_valid      <= 1'b1;
        other_latitude  <= LAT_W'(lat);
        other_longitude <= LON_W'(lon);
        do
            @(posedge clk);
        while (cand_stall);
    endtask

    function automatic int rand_span(input int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    // Mostly legal positions, some near the reference, a few raw bit patterns.
    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send(rand_span(LAT_MAX), rand_span(LON_MAX));
        else if (pick < 75)
            send(home_lat + rand_span(1 << ($urandom_range(24) + 1)),
                 home_lon + rand_span(1 << ($urandom_range(24) + 1)));
        else if (pick < 85)
            send(-home_lat + rand_span(1 << 12),
                 home_lon + LON_MAX + rand_span(1 << 12));
        else
            send($urandom, $urandom);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed candidates against the reset reference.
        send(0, 0);
        send(1, 1);
        send(LAT_MAX, 0);
        send(-LAT_MAX, 0);
        send(0, LON_MAX);
        send(0, -LON_MAX);
        send(LAT_MAX, LON_MAX);
        send(-LAT_MAX, -LON_MAX);
        send(LAT_MAX, -LON_MAX);
        send(0, LON_MAX / 2);
        send(20000, 0);
        send(21000, 0);
        send(30'sh1FFF_FFFF, 31'sh3FFF_FFFF);
        send(-(1 <<< 29), -(1 <<< 30));
        send(LAT_MAX / 2, LON_MAX / 3);
        cand_valid <= 1'b0;

        // Directed extremes of the reference and radius.
        set_home(LAT_MAX, LON_MAX, DIST_TOP);
        send(-LAT_MAX, -LON_MAX);
        send(LAT_MAX, LON_MAX);
        send(0, 0);
        cand_valid <= 1'b0;
        set_home(-LAT_MAX, -LON_MAX, 0);
        send(-LAT_MAX, -LON_MAX);
        send(LAT_MAX, LON_MAX);
        send(-LAT_MAX, LON_MAX);
        cand_valid <= 1'b0;

        // Random phases cycling through the idling patterns.
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 51; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 51; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            if (p == 3)
                set_home($urandom, $urandom, $urandom);
            else if (p == 5)
                set_home(0, 0, DIST_TOP);
            else
                set_home(rand_span(LAT_MAX), rand_span(LON_MAX),
                         $urandom_range(1 << $urandom_range(24)));
            for (int i = 0; i < PER_PHASE; i++)
                send_random();
            cand_valid <= 1'b0;
        end

        // Drain, let the latency pass, and give the verdict.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (fail_count == 0)
            $display("tb_haversine_proximity_filter_top: PASS");
        else
            $display("tb_haversine_proximity_filter_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/hpf_pkg.sv
rtl/core/hpf_div_cell.sv
rtl/core/hpf_rot_cell.sv
rtl/core/hpf_vec_cell.sv
rtl/core/hpf_sqrt_cell.sv
rtl/core/haversine_proximity_filter_top.sv
dv/hpf_checker.sv
dv/tb_haversine_proximity_filter_top.sv
